// ===== src/sci_pkg.sv =====
`timescale 1ns / 1ps

package sci_pkg;

    // Fixed field widths of the stream items.
    localparam int WORD_W       = 32;
    localparam int POS_W        = 9;
    localparam int DEF_CAPACITY = 256;

    // Packed widths of the stream buses, rounded up to whole bytes.
    localparam int S_TDATA_W = 32;
    localparam int M_TDATA_W = 24;

    // Token that walks down the cell chain during a sorted insert.
    typedef struct packed {
        logic              tok;    // token present
        logic              shift;  // 1: carrying a displaced entry, 0: still searching
        logic [WORD_W-1:0] word;
    } link_t;

    // Direct write into the cell that sits at the fill count.
    typedef struct packed {
        logic              en;
        logic [WORD_W-1:0] word;
    } wr_t;

    // Controller states.
    typedef enum logic [1:0] {
        ST_IDLE = 2'b01,
        ST_WALK = 2'b10
    } state_t;

endpackage

// ===== src/sorted_column_insert_core.sv =====
`timescale 1ns / 1ps

// Sorted column store with a fill count, built as a row of cells.
// Input channel (s_*): one transfer carries a value in s_tdata and the
// operation in s_tuser (0 append at the end, 1 insert in ascending order).
// Output channel (m_*): one transfer per input item with the insert position,
// the new fill count and, in m_tuser, a flag that the store was full and the
// item was rejected.
// An append or a rejected item shows its result in the cycle after the input
// transfer. A sorted insert launches a token into cell 0 that moves one cell
// per cycle, comparing and then shifting entries up as it goes, and stops at
// the cell at the fill count; its result shows once the token reaches it.
// Throughput: one item at a time; a new item is taken in the cycle its
// predecessor's result is shown, so appends sustain one item every cycle
// while the receiver keeps up.
// Reset clears the fill count and the handshakes; stored values are not
// cleared and are never read before they are written.
// When the receiver stalls, the result is held in the output register and a
// new item is taken only once that register frees up in the same cycle.
module sorted_column_insert_core
#(
    parameter int CAPACITY = sci_pkg::DEF_CAPACITY
)
(
    input  logic                          clk,
    input  logic                          rst_n,
    input  logic                          s_tvalid,
    output logic                          s_tready,
    input  logic [sci_pkg::S_TDATA_W-1:0] s_tdata,   // [31:0] value
    input  logic                          s_tuser,   // [0] func
    output logic                          m_tvalid,
    input  logic                          m_tready,
    output logic [sci_pkg::M_TDATA_W-1:0] m_tdata,   // [8:0] position, [17:9] fill_count
    output logic                          m_tuser    // [0] full_res
);

    localparam int CW = $clog2(CAPACITY + 1);
    localparam int EW = (CW > sci_pkg::POS_W) ? CW : sci_pkg::POS_W;

    sci_pkg::state_t state_reg;
    sci_pkg::state_t state_next;
    logic [CW-1:0]   count_reg;
    logic [CW-1:0]   count_next;
    logic [CW-1:0]   idx_reg;
    logic [CW-1:0]   idx_next;
    logic [CW-1:0]   found_reg;
    logic [CW-1:0]   found_next;
    logic            srch_reg;
    logic            srch_next;
    sci_pkg::link_t  launch_reg;
    sci_pkg::link_t  launch_next;
    logic            out_valid_reg;
    logic            out_valid_next;
    logic [CW-1:0]   out_pos_reg;
    logic [CW-1:0]   out_pos_next;
    logic [CW-1:0]   out_fill_reg;
    logic [CW-1:0]   out_fill_next;
    logic            out_full_reg;
    logic            out_full_next;

    sci_pkg::link_t  links [CAPACITY+1];
    logic [CAPACITY-1:0] hit_vec;
    logic            any_hit;
    logic            full;
    logic            accept;
    logic            walk_done;
    sci_pkg::wr_t    app_wr;
    logic [EW-1:0]   pos_ext;
    logic [EW-1:0]   fill_ext;

    assign full      = (count_reg == CW'(CAPACITY));
    assign s_tready  = (state_reg == sci_pkg::ST_IDLE) && (!out_valid_reg || m_tready);
    assign accept    = s_tvalid && s_tready;
    assign any_hit   = |hit_vec;
    assign walk_done = (state_reg == sci_pkg::ST_WALK) && (idx_reg == count_reg);

    // An append writes straight into the cell at the fill count.
    assign app_wr.en   = accept && !full && !s_tuser;
    assign app_wr.word = s_tdata[sci_pkg::WORD_W-1:0];

    assign links[0] = launch_reg;

    // Row of cells; cell i acts on the token in the cycle idx_reg equals i.
    for (genvar i = 0; i < CAPACITY; i++)
    begin : g_cell
        sci_cell u_cell
        (
            .clk      (clk),
            .rst_n    (rst_n),
            .link_in  (links[i]),
            .wr       (app_wr),
            .is_end   (count_reg == CW'(i)),
            .link_out (links[i+1]),
            .hit      (hit_vec[i])
        );
    end

    // Controller: accept, launch the token, follow it and build the result.
    always_comb
    begin
        state_next      = state_reg;
        count_next      = count_reg;
        idx_next        = idx_reg;
        found_next      = found_reg;
        srch_next       = srch_reg;
        launch_next.tok   = 1'b0;
        launch_next.shift = 1'b0;
        launch_next.word  = s_tdata[sci_pkg::WORD_W-1:0];
        out_valid_next  = out_valid_reg && !m_tready;
        out_pos_next    = out_pos_reg;
        out_fill_next   = out_fill_reg;
        out_full_next   = out_full_reg;
        case (state_reg)
            sci_pkg::ST_IDLE:
            begin
                if (accept)
                begin
                    if (full)
                    begin
                        out_valid_next = 1'b1;
                        out_pos_next   = count_reg;
                        out_fill_next  = count_reg;
                        out_full_next  = 1'b1;
                    end
                    else if (!s_tuser)
                    begin
                        count_next     = count_reg + 1'b1;
                        out_valid_next = 1'b1;
                        out_pos_next   = count_reg;
                        out_fill_next  = count_reg + 1'b1;
                        out_full_next  = 1'b0;
                    end
                    else
                    begin
                        launch_next.tok = 1'b1;
                        idx_next        = '0;
                        srch_next       = 1'b1;
                        state_next      = sci_pkg::ST_WALK;
                    end
                end
            end
            sci_pkg::ST_WALK:
            begin
                if (srch_reg && any_hit)
                begin
                    found_next = idx_reg;
                    srch_next  = 1'b0;
                end
                if (walk_done)
                begin
                    count_next     = count_reg + 1'b1;
                    out_valid_next = 1'b1;
                    out_pos_next   = srch_reg ? idx_reg : found_reg;
                    out_fill_next  = count_reg + 1'b1;
                    out_full_next  = 1'b0;
                    state_next     = sci_pkg::ST_IDLE;
                end
                else
                begin
                    idx_next = idx_reg + 1'b1;
                end
            end
            default:
            begin
                state_next = sci_pkg::ST_IDLE;
            end
        endcase
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            state_reg     <= sci_pkg::ST_IDLE;
            count_reg     <= '0;
            launch_reg    <= '0;
            out_valid_reg <= 1'b0;
            srch_reg      <= 1'b0;
        end
        else
        begin
            state_reg     <= state_next;
            count_reg     <= count_next;
            launch_reg    <= launch_next;
            out_valid_reg <= out_valid_next;
            srch_reg      <= srch_next;
        end
    end

    // Walk index and result payload need no reset.
    always_ff @(posedge clk)
    begin
        idx_reg      <= idx_next;
        found_reg    <= found_next;
        out_pos_reg  <= out_pos_next;
        out_fill_reg <= out_fill_next;
        out_full_reg <= out_full_next;
    end

    // Result fields carry the low nine bits of position and count.
    assign pos_ext  = EW'(out_pos_reg);
    assign fill_ext = EW'(out_fill_reg);
    assign m_tvalid = out_valid_reg;
    assign m_tdata  = {{(sci_pkg::M_TDATA_W - 2 * sci_pkg::POS_W){1'b0}},
                       fill_ext[sci_pkg::POS_W-1:0], pos_ext[sci_pkg::POS_W-1:0]};
    assign m_tuser  = out_full_reg;

endmodule

// ===== src/sci_cell.sv =====
`timescale 1ns / 1ps

module sci_cell
(
    input  logic           clk,
    input  logic           rst_n,
    input  sci_pkg::link_t link_in,
    input  sci_pkg::wr_t   wr,
    input  logic           is_end,
    output sci_pkg::link_t link_out,
    output logic           hit
);

    logic [sci_pkg::WORD_W-1:0] entry_reg;
    logic [sci_pkg::WORD_W-1:0] entry_next;
    sci_pkg::link_t             link_reg;
    sci_pkg::link_t             link_next;
    logic                       ge;

    // Signed compare of the stored entry against the searched value.
    assign ge = $signed(entry_reg) >= $signed(link_in.word);

    // Cell action: take a direct write, stop the token at the end cell, swap the
    // carried word with the stored entry and pass the old one on, or pass it on.
    always_comb
    begin
        entry_next      = entry_reg;
        link_next.tok   = 1'b0;
        link_next.shift = link_in.shift;
        link_next.word  = link_in.word;
        hit             = 1'b0;
        if (wr.en && is_end)
        begin
            entry_next = wr.word;
        end
        if (link_in.tok)
        begin
            if (is_end)
            begin
                entry_next = link_in.word;
            end
            else if (link_in.shift || ge)
            begin
                entry_next      = link_in.word;
                link_next.tok   = 1'b1;
                link_next.shift = 1'b1;
                link_next.word  = entry_reg;
                hit             = !link_in.shift;
            end
            else
            begin
                link_next.tok = 1'b1;
            end
        end
    end

    // The stored entry holds no reset value.
    always_ff @(posedge clk)
    begin
        entry_reg <= entry_next;
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            link_reg <= '0;
        end
        else
        begin
            link_reg <= link_next;
        end
    end

    assign link_out = link_reg;

endmodule

// ===== src/sci_checker.sv =====
`timescale 1ns / 1ps

module sci_checker
#(
    parameter int CAPACITY = sci_pkg::DEF_CAPACITY
)
(
    input logic                          clk,
    input logic                          rst_n,
    input logic                          s_tvalid,
    input logic                          s_tready,
    input logic [sci_pkg::S_TDATA_W-1:0] s_tdata,
    input logic                          s_tuser,
    input logic                          m_tvalid,
    input logic                          m_tready,
    input logic [sci_pkg::M_TDATA_W-1:0] m_tdata,
    input logic                          m_tuser
);

    // A stalled result keeps its payload.
    a_hold: assert property (@(posedge clk) disable iff (!rst_n)
        m_tvalid && !m_tready |=> m_tvalid && $stable(m_tdata) && $stable(m_tuser))
        else $error("result changed while stalled");

    // A rejected item reports the count as its position.
    a_reject_pos: assert property (@(posedge clk) disable iff (!rst_n)
        m_tvalid && m_tuser |-> m_tdata[8:0] == m_tdata[17:9])
        else $error("rejected item position differs from count");

    // A placed value lies below the new count.
    a_placed: assert property (@(posedge clk) disable iff (!rst_n)
        m_tvalid && !m_tuser && (CAPACITY < 512) |->
            m_tdata[8:0] < m_tdata[17:9])
        else $error("placed position not below new count");

    // An append item, placed or rejected, shows its result in the cycle after its transfer.
    a_one_item: assert property (@(posedge clk) disable iff (!rst_n)
        s_tvalid && s_tready && !s_tuser |=> m_tvalid)
        else $error("append result missing one cycle after transfer");

endmodule

bind sorted_column_insert_core sci_checker #(.CAPACITY(CAPACITY)) u_sci_checker
(
    .clk      (clk),
    .rst_n    (rst_n),
    .s_tvalid (s_tvalid),
    .s_tready (s_tready),
    .s_tdata  (s_tdata),
    .s_tuser  (s_tuser),
    .m_tvalid (m_tvalid),
    .m_tready (m_tready),
    .m_tdata  (m_tdata),
    .m_tuser  (m_tuser)
);

// ===== tb/tb_sorted_column_insert_core.sv =====
`timescale 1ns / 1ps

module tb_sorted_column_insert_core;

    localparam int COLUMN_DEPTH = sci_pkg::DEF_CAPACITY;
    localparam int RANDOM_ITEMS = 1230;
    localparam int CYCLE_LIMIT  = 600000;
    localparam int SETTLE_WAIT  = COLUMN_DEPTH + 40;

    // Operation codes carried in s_tuser.
    localparam logic OP_APPEND = 1'b0;
    localparam logic OP_INSERT = 1'b1;

    // One result item as the block reports it.
    typedef struct packed {
        logic [sci_pkg::POS_W-1:0] position;
        logic [sci_pkg::POS_W-1:0] fill_count;
        logic                      full_res;
    } placement_t;

    // One row of the directed stimulus; the result is only used when typed is set.
    typedef struct {
        logic        op;
        logic [31:0] value;
        bit          typed;
        placement_t  result;
    } dir_row_t;

    logic                          clk = 1'b0;
    logic                          rst_n;
    logic                          s_tvalid;
    logic                          s_tready;
    logic [sci_pkg::S_TDATA_W-1:0] s_tdata;
    logic                          s_tuser;
    logic                          m_tvalid;
    logic                          m_tready = 1'b0;
    logic [sci_pkg::M_TDATA_W-1:0] m_tdata;
    logic                          m_tuser;

    // Shadow copy of the column used for prediction.
    logic signed [31:0] col_words [COLUMN_DEPTH];
    int                 col_count;

    placement_t pending_placements[$];
    int         mismatches = 0;
    bit         tx_quiet;
    bit         rx_quiet;

    // Directed rows: empty column, extremes, equal entries, out-of-order column.
    dir_row_t directed_rows [19] = '{
        '{OP_INSERT, 32'h0000_0000, 1'b1, '{9'd0, 9'd1, 1'b0}},
        '{OP_APPEND, 32'h7FFF_FFFF, 1'b1, '{9'd1, 9'd2, 1'b0}},
        '{OP_INSERT, 32'h8000_0000, 1'b1, '{9'd0, 9'd3, 1'b0}},
        '{OP_INSERT, 32'h0000_0000, 1'b1, '{9'd1, 9'd4, 1'b0}},
        '{OP_INSERT, 32'h7FFF_FFFF, 1'b1, '{9'd3, 9'd5, 1'b0}},
        '{OP_APPEND, 32'h8000_0000, 1'b1, '{9'd5, 9'd6, 1'b0}},
        '{OP_INSERT, 32'hFFFF_FFFF, 1'b0, '0},
        '{OP_APPEND, 32'h0000_0005, 1'b0, '0},
        '{OP_INSERT, 32'h0000_0003, 1'b0, '0},
        '{OP_INSERT, 32'h8000_0000, 1'b0, '0},
        '{OP_INSERT, 32'h7FFF_FFFF, 1'b0, '0},
        '{OP_APPEND, 32'h0000_0000, 1'b0, '0},
        '{OP_INSERT, 32'h5555_5555, 1'b0, '0},
        '{OP_APPEND, 32'hAAAA_AAAA, 1'b0, '0},
        '{OP_INSERT, 32'h1234_5678, 1'b0, '0},
        '{OP_INSERT, 32'hFFFF_FFFF, 1'b0, '0},
        '{OP_APPEND, 32'h0000_0001, 1'b0, '0},
        '{OP_INSERT, 32'h8000_0001, 1'b0, '0},
        '{OP_INSERT, 32'h7FFF_FFFE, 1'b0, '0}
    };

    sorted_column_insert_core DUT
    (
        .clk      (clk),
        .rst_n    (rst_n),
        .s_tvalid (s_tvalid),
        .s_tready (s_tready),
        .s_tdata  (s_tdata),
        .s_tuser  (s_tuser),
        .m_tvalid (m_tvalid),
        .m_tready (m_tready),
        .m_tdata  (m_tdata),
        .m_tuser  (m_tuser)
    );

    always
    begin
        #1 clk = 1'b1;
        #1 clk = 1'b0;
    end

    // Apply one item to the shadow column and return the result it causes.
    function automatic placement_t place_value(input logic op, input logic signed [31:0] value);
        placement_t res;
        int         slot;
        if (col_count >= COLUMN_DEPTH)
        begin
            res.position   = sci_pkg::POS_W'(col_count);
            res.fill_count = sci_pkg::POS_W'(col_count);
            res.full_res   = 1'b1;
            return res;
        end
        slot = col_count;
        if (op == OP_INSERT)
        begin
            // The value takes the slot of the first entry not below it; that entry and later ones move up.
            for (int i = 0; i < col_count; i++)
            begin
                if (col_words[i] >= value)
                begin
                    slot = i;
                    break;
                end
            end
            for (int i = col_count; i > slot; i--)
                col_words[i] = col_words[i - 1];
        end
        col_words[slot] = value;
        col_count++;
        res.position   = sci_pkg::POS_W'(slot);
        res.fill_count = sci_pkg::POS_W'(col_count);
        res.full_res   = 1'b0;
        return res;
    endfunction

    // Values lean toward a narrow band so that equal entries are common.
    function automatic logic [31:0] pick_value();
        int sel;
        sel = $urandom_range(9);
        if (sel < 3)
            return 32'($signed($urandom_range(16)) - 8);
        if (sel == 3)
        begin
            case ($urandom_range(3))
                0: return 32'h8000_0000;
                1: return 32'h7FFF_FFFF;
                2: return 32'hFFFF_FFFF;
                default: return 32'h0000_0000;
            endcase
        end
        return $urandom();
    endfunction

    // Offer one item, wait for its transfer and record the expected result.
    task automatic send_item(input logic op, input logic [31:0] value, input bit typed,
                             input placement_t typed_result);
        placement_t predicted;
        while (!tx_quiet && $urandom_range(99) < 15)
        begin
            s_tvalid <= 1'b0;
            @(posedge clk);
        end
        s_tvalid <= 1'b1;
        s_tdata  <= value;
        s_tuser  <= op;
        @(posedge clk);
        while (!s_tready)
            @(posedge clk);
        predicted = place_value(op, value);
        pending_placements.push_back(typed ? typed_result : predicted);
    endtask

    task automatic wait_drained();
        while (pending_placements.size() != 0)
            @(posedge clk);
    endtask

    // Compare each result transfer with the oldest pending expectation.
    always @(posedge clk)
    begin : result_check
        placement_t got;
        placement_t want;
        if (rst_n && m_tvalid && m_tready)
        begin
            got.position   = m_tdata[sci_pkg::POS_W-1:0];
            got.fill_count = m_tdata[2*sci_pkg::POS_W-1:sci_pkg::POS_W];
            got.full_res   = m_tuser;
            if (pending_placements.size() == 0)
            begin
                mismatches++;
                if (mismatches <= 10)
                    $display("Unexpected result: position %0d fill_count %0d full %0b",
                             got.position, got.fill_count, got.full_res);
            end
            else
            begin
                want = pending_placements.pop_front();
                if (got.position !== want.position || got.fill_count !== want.fill_count ||
                    got.full_res !== want.full_res)
                begin
                    mismatches++;
                    if (mismatches <= 10)
                        $display("Mismatch: expected %0d %0d %0b, got %0d %0d %0b",
                                 want.position, want.fill_count, want.full_res,
                                 got.position, got.fill_count, got.full_res);
                end
            end
        end
        m_tready <= rx_quiet || ($urandom_range(99) >= 15);
    end

    initial
    begin : watchdog
        repeat (CYCLE_LIMIT) @(posedge clk);
        $display("Some tests failed");
        $finish;
    end

    initial
    begin : stimulus
        logic op;
        rst_n      = 1'b0;
        s_tvalid   = 1'b0;
        s_tdata    = '0;
        s_tuser    = OP_APPEND;
        col_count  = 0;
        tx_quiet   = 1'b0;
        rx_quiet   = 1'b0;
        repeat (8) @(posedge clk);
        rst_n <= 1'b1;
        @(posedge clk);

        // Directed rows.
        foreach (directed_rows[i])
            send_item(directed_rows[i].op, directed_rows[i].value,
                      directed_rows[i].typed, directed_rows[i].result);
        s_tvalid <= 1'b0;
        wait_drained();

        // Random items; the column fills up and later items are rejected.
        for (int n = 0; n < RANDOM_ITEMS; n++)
        begin
            tx_quiet = (n >= 400 && n < 700);
            rx_quiet = tx_quiet;
            if (n == 150)
            begin
                s_tvalid <= 1'b0;
                wait_drained();
            end
            op = ($urandom_range(99) < 70) ? OP_INSERT : OP_APPEND;
            send_item(op, pick_value(), 1'b0, '0);
        end
        s_tvalid <= 1'b0;
        tx_quiet = 1'b0;
        rx_quiet = 1'b0;

        // Let the last results come in, then allow for a full token walk.
        wait_drained();
        repeat (SETTLE_WAIT) @(posedge clk);
        if (mismatches == 0 && pending_placements.size() == 0)
            $display("All tests passed");
        else
            $display("Some tests failed");
        $finish;
    end

endmodule

// ===== files.f =====
src/sci_pkg.sv
src/sci_cell.sv
src/sorted_column_insert_core.sv
src/sci_checker.sv
tb/tb_sorted_column_insert_core.sv
